// ===== hdl/assert_macros.svh =====
// Assertion helpers, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define APRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define APRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/apra_pkg.sv =====
package apra_pkg;

  localparam int SIZE_W   = 13;
  localparam int START_W  = 12;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // Sequencer steps (ROM addresses).
  typedef enum logic [3:0] {
    S_CLR  = 4'd0,
    S_IDLE = 4'd1,
    S_BADQ = 4'd2,
    S_FIT  = 4'd3,
    S_RSV  = 4'd4,
    S_RD   = 4'd5,
    S_TST  = 4'd6,
    S_DEC  = 4'd7,
    S_MK0  = 4'd8,
    S_MRD  = 4'd9,
    S_MWR  = 4'd10,
    S_DONE = 4'd11,
    S_RET  = 4'd12,
    S_ADV  = 4'd13,
    S_JMP  = 4'd14
  } step_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_CLR,
    A_LOAD,
    A_BAD,
    A_NOFIT,
    A_RSV,
    A_TST,
    A_DEC,
    A_MK0,
    A_MARK,
    A_EMIT,
    A_ADV
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_W_NOT_LAST,
    C_NO_IN,
    C_BAD,
    C_OVER,
    C_IN_RSV,
    C_HIT,
    C_ABOVE_LO,
    C_BELOW_HI,
    C_OUT_BUSY,
    C_S_LE_J
  } cond_t;

  // One control word: action, jump condition, jump target (else fall through).
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t tgt;
  } uword_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t uw;
    case (pc)
      S_CLR:   uw = '{A_CLR,   C_W_NOT_LAST, S_CLR};
      S_IDLE:  uw = '{A_LOAD,  C_NO_IN,      S_IDLE};
      S_BADQ:  uw = '{A_BAD,   C_BAD,        S_DONE};
      S_FIT:   uw = '{A_NOFIT, C_OVER,       S_DONE};
      S_RSV:   uw = '{A_RSV,   C_IN_RSV,     S_ADV};
      S_RD:    uw = '{A_NOP,   C_NEVER,      S_IDLE};
      S_TST:   uw = '{A_TST,   C_HIT,        S_ADV};
      S_DEC:   uw = '{A_DEC,   C_ABOVE_LO,   S_RD};
      S_MK0:   uw = '{A_MK0,   C_NEVER,      S_IDLE};
      S_MRD:   uw = '{A_NOP,   C_NEVER,      S_IDLE};
      S_MWR:   uw = '{A_MARK,  C_BELOW_HI,   S_MRD};
      S_DONE:  uw = '{A_EMIT,  C_OUT_BUSY,   S_DONE};
      S_RET:   uw = '{A_NOP,   C_ALWAYS,     S_IDLE};
      S_ADV:   uw = '{A_ADV,   C_S_LE_J,     S_ADV};
      S_JMP:   uw = '{A_NOP,   C_ALWAYS,     S_FIT};
      default: uw = '{A_NOP,   C_ALWAYS,     S_IDLE};
    endcase
    return uw;
  endfunction

endpackage

// ===== hdl/aligned_page_run_allocator_top.sv =====
// Channel   Dir  Handshake          Payload
// in_*      in   in_tvalid/tready   tdata: size_pages[12:0], align_pages[25:13]
// out_*     out  out_tvalid/tready  tdata: status[1:0], start_page[13:2]
// cfg_*     in   cfg_we             cfg_wdata: reserved_pages
//
// One request at a time; in_tready is high only while the sequencer idles.
// Per request: 3 check steps; a read, a test and a step down per bitmap word;
// an advance per alignment step past a used page, a restart; a set-up and a
// read and write per word marked; emit and return; one RAM read port paces it.
// After reset a clearing pass writes WORD_COUNT words, one per cycle, first.
// The sequencer takes the next request while a result waits on out_tready.
module aligned_page_run_allocator_top
  import apra_pkg::*;
#(
  parameter int PAGE_COUNT = 4096,
  parameter int WORD_BITS  = 32     // power of two
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // size_pages[12:0], align_pages[25:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // status[1:0], start_page[13:2]
  input  logic        cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata  // reserved_pages
);

  localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WIW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  // candidate start stays below PAGE_COUNT + align; its run end below that + size
  localparam int SW         = $clog2(PAGE_COUNT + 3 * (2 ** SIZE_W));
  localparam logic [SW-1:0]  PAGE_LIM = SW'(PAGE_COUNT);
  localparam logic [WIW-1:0] LAST_W   = WIW'(WORD_COUNT - 1);

  // sequencer and datapath registers
  step_t               pc_r, pc_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [SIZE_W-1:0]   align_r, align_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  logic [SW-1:0]       j_r, j_nxt;        // skip bound: next start must pass it
  logic [WIW-1:0]      w_r, w_nxt;
  status_t             status_r, status_nxt;
  logic [SIZE_W-1:0]   reserved_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;

  // bitmap RAM
  logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  uword_t              uw;
  logic                jump;
  logic                out_busy;
  logic [SW-1:0]       run_end, hi_page, s_adv, rsv_ext, word_base;
  logic [WIW-1:0]      lo_word, hi_word;
  logic [BIT_W-1:0]    lo_bit, hi_bit;
  logic [WORD_BITS-1:0] word_mask;
  logic                hit;

  assign uw       = ucode(pc_r);
  assign out_busy = out_valid_r && !out_tready;

  assign run_end   = s_r + SW'(size_r);
  assign hi_page   = run_end - SW'(1);
  assign s_adv     = s_r + SW'(align_r);
  assign rsv_ext   = SW'(reserved_r);
  assign lo_word   = WIW'(s_r >> BIT_W);
  assign hi_word   = WIW'(hi_page >> BIT_W);
  assign word_base = SW'(w_r) << BIT_W;

  // pages of the current run that fall in word w_r
  assign lo_bit    = (w_r == lo_word) ? s_r[BIT_W-1:0] : '0;
  assign hi_bit    = (w_r == hi_word) ? hi_page[BIT_W-1:0] : '1;
  assign word_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (~hi_bit));
  assign hit       = (rdata_r & word_mask) != '0;

  assign mem_we    = (uw.act == A_CLR) || (uw.act == A_MARK);
  assign mem_wdata = (uw.act == A_CLR) ? '0 : (rdata_r | word_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[w_r] <= mem_wdata;
    end
    rdata_r <= bitmap_mem[w_r];
  end

  // jump condition
  always_comb begin
    case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_W_NOT_LAST: jump = (w_r != LAST_W);
      C_NO_IN:      jump = !in_tvalid;
      C_BAD:        jump = (size_r == '0) || (align_r == '0);
      C_OVER:       jump = (run_end > PAGE_LIM);
      C_IN_RSV:     jump = (s_r < rsv_ext);
      C_HIT:        jump = hit;
      C_ABOVE_LO:   jump = (w_r != lo_word);
      C_BELOW_HI:   jump = (w_r != hi_word);
      C_OUT_BUSY:   jump = out_busy;
      C_S_LE_J:     jump = (s_adv <= j_r);
      default:      jump = 1'b1;
    endcase
  end

  // next step and datapath actions
  always_comb begin
    pc_nxt         = jump ? uw.tgt : step_t'(pc_r + 4'd1);
    size_nxt       = size_r;
    align_nxt      = align_r;
    s_nxt          = s_r;
    j_nxt          = j_r;
    w_nxt          = w_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;

    case (uw.act)
      A_CLR: begin
        w_nxt = w_r + WIW'(1);
      end
      A_LOAD: begin
        if (in_tvalid) begin
          size_nxt  = in_tdata[SIZE_W-1:0];
          align_nxt = in_tdata[2*SIZE_W-1:SIZE_W];
          s_nxt     = '0;
        end
      end
      A_BAD:   status_nxt = ST_BAD;
      A_NOFIT: status_nxt = ST_NOFIT;
      A_RSV: begin
        // scan starts at the top word; reserved pages skip without a read
        w_nxt = hi_word;
        j_nxt = (rsv_ext - SW'(1) < hi_page) ? rsv_ext - SW'(1) : hi_page;
      end
      A_TST: begin
        if (hit) begin
          j_nxt = (word_base > s_r) ? word_base : s_r;
        end
      end
      A_DEC: w_nxt = w_r - WIW'(1);
      A_MK0: begin
        w_nxt      = lo_word;
        status_nxt = ST_OK;
      end
      A_MARK: w_nxt = w_r + WIW'(1);
      A_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_start_nxt  = (status_r == ST_OK) ? s_r[START_W-1:0] : '0;
        end
      end
      A_ADV: s_nxt = s_adv;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_CLR;
      w_r         <= '0;
      out_valid_r <= 1'b0;
      reserved_r  <= SIZE_W'(1);
    end else begin
      pc_r        <= pc_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        reserved_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    align_r      <= align_nxt;
    s_r          <= s_nxt;
    j_r          <= j_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  assign in_tready  = (pc_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_start_r, out_status_r};

`include "assert_macros.svh"

  `APRA_ASSERT_NEXT(a_load_checks, in_tvalid && in_tready, pc_r == S_BADQ, "accepted request did not start checks")
  `APRA_ASSERT_NEXT(a_emit, (pc_r == S_DONE) && !out_busy, out_tvalid && (out_tdata[1:0] == status_r), "result not presented")
  `APRA_ASSERT_NOW(a_skip_past, pc_r == S_JMP, s_r > j_r, "next candidate does not clear the used page")
  `APRA_ASSERT_NOW(a_mark_free, pc_r == S_MWR, (rdata_r & word_mask) == '0, "marking a page already in use")

endmodule
